FILE: hdl/umcfp_pkg.sv
// Package for the UART motor command frame parser: payload structs, status,
// action, mode and command codes, controller types. No dependencies.
`default_nettype none

package umcfp_pkg;

    // Input item: one received byte or an external mode write
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       chunk_end;
        logic [3:0] mode_write;
    } in_item_t;

    // Result item: one per chunk
    typedef struct packed {
        logic [2:0]         frame_status;
        logic [7:0]         command_code;
        logic [2:0]         action;
        logic [7:0]         arg_first;
        logic [6:0]         arg_second;
        logic [15:0]        repeat_count;
        logic signed [15:0] speed;
        logic [31:0]        increment;
        logic [1:0]         power_command;
        logic [3:0]         mode;
        logic               print_enable;
    } out_item_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE      = 2'd1;
    localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd1;
    localparam logic [19:0] TICK_RATE_RESET      = 20'd20000;

    // Frame layout
    localparam int HEAD_DEPTH = 11;
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // Frame status codes
    localparam logic [2:0] ST_EXECUTED  = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_SUM_ERR   = 3'd4;
    localparam logic [2:0] ST_OTHER_ID  = 3'd5;
    localparam logic [2:0] ST_FAULT     = 3'd6;

    // Actions
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_REPEAT     = 3'd1;
    localparam logic [2:0] ACT_POSITION   = 3'd2;
    localparam logic [2:0] ACT_STOP       = 3'd3;
    localparam logic [2:0] ACT_STEP_PLUS  = 3'd4;
    localparam logic [2:0] ACT_STEP_MINUS = 3'd5;
    localparam logic [2:0] ACT_VELOCITY   = 3'd6;

    // Power commands
    localparam logic [1:0] PWR_KEEP = 2'd0;
    localparam logic [1:0] PWR_ON   = 2'd1;
    localparam logic [1:0] PWR_OFF  = 2'd2;

    // Motor modes
    localparam logic [3:0] MODE_IDLE         = 4'd0;
    localparam logic [3:0] MODE_READY        = 4'd1;
    localparam logic [3:0] MODE_OPEN_REPEAT  = 4'd2;
    localparam logic [3:0] MODE_OPEN_POS     = 4'd3;
    localparam logic [3:0] MODE_OPEN_VEL     = 4'd4;
    localparam logic [3:0] MODE_CLOSED_POS   = 4'd5;
    localparam logic [3:0] MODE_CLOSED_FORCE = 4'd6;
    localparam logic [3:0] MODE_ERROR        = 4'd7;
    localparam logic [3:0] MODE_FAULT_A      = 4'd8;
    localparam logic [3:0] MODE_FAULT_B      = 4'd9;
    localparam logic [3:0] MODE_FAULT_C      = 4'd10;

    // Command codes
    localparam logic [7:0] CMD_REPEAT     = 8'h24;
    localparam logic [7:0] CMD_STOP       = 8'h25;
    localparam logic [7:0] CMD_POSITION   = 8'h27;
    localparam logic [7:0] CMD_STEP_PLUS  = 8'h28;
    localparam logic [7:0] CMD_STEP_MINUS = 8'h29;
    localparam logic [7:0] CMD_VELOCITY   = 8'h31;
    localparam logic [7:0] CMD_CLOSED_POS = 8'h32;
    localparam logic [7:0] CMD_CLOSED_FRC = 8'h33;

    // Phase increment divider: magnitude shifted up by 32, one quotient bit a cycle
    localparam int MAG_W     = 15;
    localparam int DIV_STEPS = MAG_W + 32;
    localparam int DIV_CNT_W = 6;
    localparam logic [MAG_W-1:0] STEP_MAG = 15'd10;

    // Controller
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EVAL,
        CS_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic take;      // input transfer this cycle
        logic eval;      // judge the finished chunk
        logic div_step;  // one divider iteration
    } dp_cmd_t;

    typedef struct packed {
        logic item_func;
        logic item_last;
        logic need_div;
        logic div_last;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/umcfp_ctrl.sv
// Controller for the frame parser: state machine and result valid flag.
// Depends on umcfp_pkg.
`default_nettype none

module umcfp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire umcfp_pkg::dp_stat_t stat,
    output umcfp_pkg::dp_cmd_t      cmd
);

    umcfp_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // State and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= umcfp_pkg::CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            umcfp_pkg::CS_IDLE: begin
                // only a byte that ends a chunk needs the result slot free or emptying
                s_ready  = !m_valid_reg || m_ready || stat.item_func || !stat.item_last;
                cmd.take = s_valid && s_ready;
                if (cmd.take && !stat.item_func && stat.item_last) begin
                    state_next = umcfp_pkg::CS_EVAL;
                end
            end
            umcfp_pkg::CS_EVAL: begin
                cmd.eval = 1'b1;
                if (stat.need_div) begin
                    state_next = umcfp_pkg::CS_DIV;
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = umcfp_pkg::CS_IDLE;
                end
            end
            umcfp_pkg::CS_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    m_valid_next = 1'b1;
                    state_next   = umcfp_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = umcfp_pkg::CS_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/umcfp_datapath.sv
// Datapath for the frame parser: chunk capture, frame checks, command decode,
// serial phase increment divider and result register. Depends on umcfp_pkg.
`default_nettype none

module umcfp_datapath #(
    parameter int CHUNK_BYTES = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [umcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [umcfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire umcfp_pkg::in_item_t                 s_data,
    input  wire umcfp_pkg::dp_cmd_t                  cmd,
    output umcfp_pkg::dp_stat_t                      stat,
    output umcfp_pkg::out_item_t                     m_data
);

    localparam int POS_W = $clog2(CHUNK_BYTES + 1);
    localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
    localparam int MAG_W = umcfp_pkg::MAG_W;

    // Configuration
    logic [7:0]  dev_addr_reg;
    logic [19:0] tick_rate_reg;

    // Chunk state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       cap_reg, cap_next;
    logic [7:0]       head_reg [umcfp_pkg::HEAD_DEPTH];
    logic [7:0]       head_next[umcfp_pkg::HEAD_DEPTH];
    logic [3:0]       mode_reg, mode_next;
    logic             print_reg, print_next;

    // Divider
    logic [19:0]                       rem_reg;
    logic [MAG_W-1:0]                  mag_reg;
    logic [umcfp_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [20:0]                       rem_sh;
    logic                              q_bit;

    // Evaluation results
    logic [2:0]       ev_status, ev_action;
    logic [7:0]       ev_cmd, ev_a1;
    logic [6:0]       ev_a2;
    logic [15:0]      ev_rcnt, ev_spd;
    logic [31:0]      ev_inc;
    logic [1:0]       ev_pwr;
    logic [3:0]       ev_mode;
    logic             ev_print, ev_touch, ev_need_div;
    logic [MAG_W-1:0] ev_mag;
    logic [7:0]       len_now, len;
    logic             wants_inc;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= umcfp_pkg::DEVICE_ADDRESS_RESET;
            tick_rate_reg <= umcfp_pkg::TICK_RATE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                umcfp_pkg::REG_DEVICE_ADDRESS: dev_addr_reg  <= cfg_data[7:0];
                umcfp_pkg::REG_TICK_RATE:      tick_rate_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Byte capture, running sum and state update
    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        cap_next   = cap_reg;
        head_next  = head_reg;
        mode_next  = mode_reg;
        print_next = print_reg;
        // length byte is taken as it arrives
        len_now = (pos_reg == POS_W'(2)) ? s_data.rx_byte : head_reg[2];
        if (cmd.take) begin
            if (s_data.func) begin
                mode_next = s_data.mode_write;
            end else if (pos_reg < POS_W'(CHUNK_BYTES)) begin
                for (int i = 0; i < umcfp_pkg::HEAD_DEPTH; i++) begin
                    if (pos_reg == POS_W'(i)) begin
                        head_next[i] = s_data.rx_byte;
                    end
                end
                if (pos_reg >= POS_W'(2)) begin
                    if (CMP_W'(pos_reg) <= CMP_W'(len_now) + CMP_W'(3)) begin
                        sum_next = sum_reg + s_data.rx_byte;
                    end else if (CMP_W'(pos_reg) == CMP_W'(len_now) + CMP_W'(4)) begin
                        cap_next = s_data.rx_byte;
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
        end
        if (cmd.eval) begin
            mode_next  = ev_mode;
            print_next = ev_print;
            pos_next   = '0;
            sum_next   = '0;
            cap_next   = '0;
            for (int i = 0; i < umcfp_pkg::HEAD_DEPTH; i++) begin
                head_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            cap_reg   <= '0;
            mode_reg  <= umcfp_pkg::MODE_IDLE;
            print_reg <= 1'b0;
            for (int i = 0; i < umcfp_pkg::HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
        end else begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            cap_reg   <= cap_next;
            mode_reg  <= mode_next;
            print_reg <= print_next;
            head_reg  <= head_next;
        end
    end

    // Frame checks and command decode
    always_comb begin
        len         = head_reg[2];
        ev_status   = umcfp_pkg::ST_EXECUTED;
        ev_cmd      = '0;
        ev_action   = umcfp_pkg::ACT_NONE;
        ev_a1       = '0;
        ev_a2       = '0;
        ev_rcnt     = '0;
        ev_spd      = '0;
        ev_pwr      = umcfp_pkg::PWR_KEEP;
        ev_mode     = mode_reg;
        ev_print    = print_reg;
        ev_touch    = 1'b1;
        ev_mag      = umcfp_pkg::STEP_MAG;
        wants_inc   = 1'b0;
        if (pos_reg < POS_W'(6)) begin
            ev_status = umcfp_pkg::ST_TOO_SMALL;
            ev_touch  = 1'b0;
        end else if (head_reg[0] != umcfp_pkg::SYNC_FIRST ||
                     head_reg[1] != umcfp_pkg::SYNC_SECOND) begin
            ev_status = umcfp_pkg::ST_BAD_HEAD;
        end else if (CMP_W'(pos_reg) < CMP_W'(len) + CMP_W'(5)) begin
            ev_status = umcfp_pkg::ST_SHORT;
        end else if (sum_reg != cap_reg) begin
            ev_status = umcfp_pkg::ST_SUM_ERR;
        end else if (head_reg[3] != dev_addr_reg) begin
            ev_status = umcfp_pkg::ST_OTHER_ID;
            ev_touch  = 1'b0;
        end else if (mode_reg inside {umcfp_pkg::MODE_FAULT_A, umcfp_pkg::MODE_FAULT_B,
                                      umcfp_pkg::MODE_FAULT_C}) begin
            ev_status = umcfp_pkg::ST_FAULT;
            ev_touch  = 1'b0;
        end else begin
            ev_cmd = head_reg[4];
            if (head_reg[4] != umcfp_pkg::CMD_STOP) begin
                ev_pwr  = umcfp_pkg::PWR_ON;
                ev_mode = umcfp_pkg::MODE_READY;
            end
            case (head_reg[4])
                umcfp_pkg::CMD_REPEAT: begin
                    ev_mode   = umcfp_pkg::MODE_OPEN_REPEAT;
                    ev_action = umcfp_pkg::ACT_REPEAT;
                    ev_spd    = {head_reg[9], head_reg[8]};
                    ev_rcnt   = {head_reg[9], head_reg[10]};
                    ev_a1     = head_reg[7];
                    ev_a2     = head_reg[6][7:1];
                end
                umcfp_pkg::CMD_STOP: begin
                    ev_pwr    = umcfp_pkg::PWR_OFF;
                    ev_action = umcfp_pkg::ACT_STOP;
                    if (mode_reg != umcfp_pkg::MODE_ERROR) begin
                        ev_mode = umcfp_pkg::MODE_IDLE;
                    end
                    ev_print  = 1'b0;
                end
                umcfp_pkg::CMD_POSITION: begin
                    ev_mode   = umcfp_pkg::MODE_OPEN_POS;
                    ev_action = umcfp_pkg::ACT_POSITION;
                    ev_spd    = {head_reg[8], head_reg[7]};
                    ev_a1     = head_reg[6];
                end
                umcfp_pkg::CMD_STEP_PLUS: begin
                    ev_mode   = umcfp_pkg::MODE_OPEN_POS;
                    ev_action = umcfp_pkg::ACT_STEP_PLUS;
                    wants_inc = 1'b1;
                end
                umcfp_pkg::CMD_STEP_MINUS: begin
                    ev_mode   = umcfp_pkg::MODE_OPEN_POS;
                    ev_action = umcfp_pkg::ACT_STEP_MINUS;
                    wants_inc = 1'b1;
                end
                umcfp_pkg::CMD_VELOCITY: begin
                    ev_mode   = umcfp_pkg::MODE_OPEN_VEL;
                    ev_action = umcfp_pkg::ACT_VELOCITY;
                    ev_spd    = {head_reg[6], head_reg[5]};
                    ev_mag    = {head_reg[6][6:0], head_reg[5]};
                    // negative speed gives no increment
                    wants_inc = !head_reg[6][7];
                end
                umcfp_pkg::CMD_CLOSED_POS: ev_mode = umcfp_pkg::MODE_CLOSED_POS;
                umcfp_pkg::CMD_CLOSED_FRC: ev_mode = umcfp_pkg::MODE_CLOSED_FORCE;
                default: ;
            endcase
        end
        if (ev_touch && (ev_mode == umcfp_pkg::MODE_OPEN_POS ||
                         ev_mode == umcfp_pkg::MODE_OPEN_REPEAT)) begin
            ev_print = 1'b1;
        end
        // zero tick rate saturates without dividing
        ev_need_div = wants_inc && (tick_rate_reg != 20'd0);
        ev_inc      = (wants_inc && !ev_need_div) ? 32'hFFFF_FFFF : 32'd0;
    end

    // Restoring divider step
    always_comb begin
        rem_sh = {rem_reg, mag_reg[MAG_W-1]};
        q_bit  = (rem_sh >= {1'b0, tick_rate_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.eval) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            rem_reg <= '0;
            mag_reg <= ev_mag;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? 20'(rem_sh - {1'b0, tick_rate_reg}) : rem_sh[19:0];
            mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
        end
    end

    // Result register; the increment field doubles as the quotient register
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            m_data.frame_status  <= ev_status;
            m_data.command_code  <= ev_cmd;
            m_data.action        <= ev_action;
            m_data.arg_first     <= ev_a1;
            m_data.arg_second    <= ev_a2;
            m_data.repeat_count  <= ev_rcnt;
            m_data.speed         <= ev_spd;
            m_data.increment     <= ev_inc;
            m_data.power_command <= ev_pwr;
            m_data.mode          <= ev_mode;
            m_data.print_enable  <= ev_print;
        end else if (cmd.div_step) begin
            m_data.increment <= {m_data.increment[30:0], q_bit};
        end
    end

    // Status to the controller
    always_comb begin
        stat.item_func = s_data.func;
        stat.item_last = s_data.chunk_end;
        stat.need_div  = ev_need_div;
        stat.div_last  = (cnt_reg == umcfp_pkg::DIV_CNT_W'(umcfp_pkg::DIV_STEPS - 1));
    end

endmodule

`default_nettype wire

FILE: hdl/uart_motor_command_frame_parser.sv
// Top level of the UART motor command frame parser: controller and datapath.
// Depends on umcfp_pkg, umcfp_ctrl and umcfp_datapath.
//
// Takes received UART bytes (func 0) grouped in chunks that close on the byte
// flagged chunk_end, and external mode writes (func 1). Each chunk gives one
// result with the frame status, decoded action and the motor mode and print
// flag after the chunk. The byte that closes a chunk is followed by the
// evaluation state; for step plus, step minus and non-negative velocity
// commands with a non-zero tick rate the divider state follows, in which the
// restoring divider forms one quotient bit of the phase increment per cycle.
// s_ready stays low during evaluation and division; a byte closing a chunk
// also waits while an earlier result is held by m_ready low, other transfers
// go on meanwhile. The configuration port is always ready; index 0 is
// device_address and index 1 tick_rate_hz, and writes are meant for an
// idle block.
`default_nettype none

module uart_motor_command_frame_parser #(
    parameter int CHUNK_BYTES = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [umcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [umcfp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire umcfp_pkg::in_item_t              s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output umcfp_pkg::out_item_t                  m_data
);

    umcfp_pkg::dp_cmd_t  cmd;
    umcfp_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    umcfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    umcfp_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: hdl/umcfp_checker.sv
// Port checker for the frame parser, bound to the top level.
// Depends on umcfp_pkg and uart_motor_command_frame_parser.
`default_nettype none

module umcfp_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire umcfp_pkg::in_item_t              s_data,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire umcfp_pkg::out_item_t             m_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The byte that closes a chunk is followed by the evaluation state, input held off
    a_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.func && s_data.chunk_end |=> !s_ready)
        else $error("input taken during chunk evaluation");

    // A new result only appears after the input side was held off
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without evaluation");

    // A rejected frame carries no command
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_status != umcfp_pkg::ST_EXECUTED |->
            m_data.command_code == 8'd0 && m_data.action == umcfp_pkg::ACT_NONE &&
            m_data.increment == 32'd0 && m_data.power_command == umcfp_pkg::PWR_KEEP)
        else $error("rejected frame with command fields");

    // Only stepping and velocity carry an increment
    a_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != umcfp_pkg::ACT_STEP_PLUS &&
        m_data.action != umcfp_pkg::ACT_STEP_MINUS &&
        m_data.action != umcfp_pkg::ACT_VELOCITY |-> m_data.increment == 32'd0)
        else $error("increment on an action without one");

endmodule

bind uart_motor_command_frame_parser umcfp_checker u_checker (.*);

`default_nettype wire

FILE: verif/uart_motor_command_frame_parser_tb.sv
// Self-checking testbench for uart_motor_command_frame_parser: directed and random chunks
// over valid/ready channels, every result checked against an in-bench frame decoder.
// Depends on umcfp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module uart_motor_command_frame_parser_tb;

    localparam int CHUNK_BYTES  = 256;
    localparam int TAIL_CYCLES  = 64;     // evaluation plus full divider, with margin
    localparam int STALL_LIMIT  = 4000;
    localparam int TOTAL_ITEMS  = 1100;

    // 0x30 only powers up and readies the motor
    localparam logic [7:0] CMD_ENABLE_ONLY = 8'h30;
    localparam logic [7:0] KNOWN_CMDS [8] = '{umcfp_pkg::CMD_REPEAT, umcfp_pkg::CMD_STOP,
        umcfp_pkg::CMD_POSITION, umcfp_pkg::CMD_STEP_PLUS, umcfp_pkg::CMD_STEP_MINUS,
        umcfp_pkg::CMD_VELOCITY, umcfp_pkg::CMD_CLOSED_POS, umcfp_pkg::CMD_CLOSED_FRC};

    typedef logic [7:0] byte_q_t [$];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [umcfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [umcfp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    umcfp_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    umcfp_pkg::out_item_t m_data;

    // Pacing knobs, percent of cycles
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // Counters
    int n_errors = 0;
    int n_items = 0;
    int n_chunks = 0;
    int n_mode_writes = 0;
    int n_checked = 0;
    int stall_cycles = 0;

    // Decoder state, mirrors the block
    logic [3:0]  mode_q = umcfp_pkg::MODE_IDLE;
    logic        print_q = 1'b0;
    int          chunk_len = 0;
    logic [7:0]  sum_acc = '0;
    logic [7:0]  sum_rx = '0;
    logic [7:0]  head_q [umcfp_pkg::HEAD_DEPTH];
    logic [7:0]  dev_addr_q = umcfp_pkg::DEVICE_ADDRESS_RESET;
    logic [19:0] tick_rate_q = umcfp_pkg::TICK_RATE_RESET;

    umcfp_pkg::out_item_t pending_status [$];

    uart_motor_command_frame_parser #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Frame decoder
    // ------------------------------------------------------------------

    // Phase increment: mag * 2^32 / tick rate, saturating on a zero divisor
    function automatic logic [31:0] phase_step(input logic [15:0] mag);
        longint unsigned num;
        if (tick_rate_q == '0) return 32'hFFFF_FFFF;
        num = {16'd0, mag, 32'd0};
        num = num / {44'd0, tick_rate_q};
        return num[31:0];
    endfunction

    task automatic clear_chunk();
        chunk_len = 0;
        sum_acc = '0;
        sum_rx = '0;
        for (int i = 0; i < umcfp_pkg::HEAD_DEPTH; i++) head_q[i] = '0;
    endtask

    // Advance the decoder by one accepted transfer, queue the status it causes
    task automatic decode_rx_item(input umcfp_pkg::in_item_t it);
        umcfp_pkg::out_item_t r;
        logic [7:0]           len;
        logic                 touch_print;
        // external mode write: no result, chunk untouched
        if (it.func) begin
            mode_q = it.mode_write;
            n_mode_writes++;
            return;
        end
        // collect head bytes and the checksum, ignore bytes past the chunk store
        if (chunk_len < CHUNK_BYTES) begin
            if (chunk_len < umcfp_pkg::HEAD_DEPTH) head_q[chunk_len] = it.rx_byte;
            if (chunk_len >= 2) begin
                len = head_q[2];
                if (chunk_len <= 3 + int'(len)) sum_acc = sum_acc + it.rx_byte;
                else if (chunk_len == 4 + int'(len)) sum_rx = it.rx_byte;
            end
            chunk_len++;
        end
        if (!it.chunk_end) return;

        // frame checks, in priority order
        r = '0;
        touch_print = 1'b1;
        len = head_q[2];
        if (chunk_len < 6) begin
            r.frame_status = umcfp_pkg::ST_TOO_SMALL;
            touch_print = 1'b0;
        end else if (head_q[0] != umcfp_pkg::SYNC_FIRST ||
                     head_q[1] != umcfp_pkg::SYNC_SECOND) begin
            r.frame_status = umcfp_pkg::ST_BAD_HEAD;
        end else if (chunk_len < 5 + int'(len)) begin
            r.frame_status = umcfp_pkg::ST_SHORT;
        end else if (sum_acc != sum_rx) begin
            r.frame_status = umcfp_pkg::ST_SUM_ERR;
        end else if (head_q[3] != dev_addr_q) begin
            r.frame_status = umcfp_pkg::ST_OTHER_ID;
            touch_print = 1'b0;
        end else if (mode_q == umcfp_pkg::MODE_FAULT_A || mode_q == umcfp_pkg::MODE_FAULT_B ||
                     mode_q == umcfp_pkg::MODE_FAULT_C) begin
            r.frame_status = umcfp_pkg::ST_FAULT;
            touch_print = 1'b0;
        end else begin
            // command decode
            r.frame_status = umcfp_pkg::ST_EXECUTED;
            r.command_code = head_q[4];
            if (head_q[4] != umcfp_pkg::CMD_STOP) begin
                r.power_command = umcfp_pkg::PWR_ON;
                mode_q = umcfp_pkg::MODE_READY;
            end
            case (head_q[4])
                umcfp_pkg::CMD_REPEAT: begin
                    mode_q = umcfp_pkg::MODE_OPEN_REPEAT;
                    r.action = umcfp_pkg::ACT_REPEAT;
                    r.speed = {head_q[9], head_q[8]};
                    r.repeat_count = {head_q[9], head_q[10]};
                    r.arg_first = head_q[7];
                    r.arg_second = head_q[6][7:1];
                end
                umcfp_pkg::CMD_STOP: begin
                    r.power_command = umcfp_pkg::PWR_OFF;
                    r.action = umcfp_pkg::ACT_STOP;
                    if (mode_q != umcfp_pkg::MODE_ERROR) mode_q = umcfp_pkg::MODE_IDLE;
                    print_q = 1'b0;
                end
                umcfp_pkg::CMD_POSITION: begin
                    mode_q = umcfp_pkg::MODE_OPEN_POS;
                    r.action = umcfp_pkg::ACT_POSITION;
                    r.speed = {head_q[8], head_q[7]};
                    r.arg_first = head_q[6];
                end
                umcfp_pkg::CMD_STEP_PLUS, umcfp_pkg::CMD_STEP_MINUS: begin
                    mode_q = umcfp_pkg::MODE_OPEN_POS;
                    r.action = (head_q[4] == umcfp_pkg::CMD_STEP_PLUS) ?
                               umcfp_pkg::ACT_STEP_PLUS : umcfp_pkg::ACT_STEP_MINUS;
                    r.increment = phase_step({1'b0, umcfp_pkg::STEP_MAG});
                end
                umcfp_pkg::CMD_VELOCITY: begin
                    mode_q = umcfp_pkg::MODE_OPEN_VEL;
                    r.action = umcfp_pkg::ACT_VELOCITY;
                    r.speed = {head_q[6], head_q[5]};
                    r.increment = r.speed[15] ? 32'd0 : phase_step(r.speed);
                end
                umcfp_pkg::CMD_CLOSED_POS: mode_q = umcfp_pkg::MODE_CLOSED_POS;
                umcfp_pkg::CMD_CLOSED_FRC: mode_q = umcfp_pkg::MODE_CLOSED_FORCE;
                default: ;
            endcase
        end

        if (touch_print && (mode_q == umcfp_pkg::MODE_OPEN_POS ||
                            mode_q == umcfp_pkg::MODE_OPEN_REPEAT))
            print_q = 1'b1;
        r.mode = mode_q;
        r.print_enable = print_q;
        pending_status.push_back(r);
        n_chunks++;
        clear_chunk();
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t ns, result %0d: %s", $time, n_checked, what);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Result channel: compare each transfer with the oldest expected status
    always @(posedge aclk) begin : result_check
        umcfp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (pending_status.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = pending_status.pop_front();
                check_field("frame_status", 32'(m_data.frame_status),
                            32'(want.frame_status));
                check_field("command_code", 32'(m_data.command_code),
                            32'(want.command_code));
                check_field("action", 32'(m_data.action), 32'(want.action));
                check_field("arg_first", 32'(m_data.arg_first), 32'(want.arg_first));
                check_field("arg_second", 32'(m_data.arg_second), 32'(want.arg_second));
                check_field("repeat_count", 32'(m_data.repeat_count),
                            32'(want.repeat_count));
                check_field("speed", 32'(m_data.speed), 32'(want.speed));
                check_field("increment", m_data.increment, want.increment);
                check_field("power_command", 32'(m_data.power_command),
                            32'(want.power_command));
                check_field("mode", 32'(m_data.mode), 32'(want.mode));
                check_field("print_enable", 32'(m_data.print_enable),
                            32'(want.print_enable));
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_status.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; each is entered and left at a falling edge
    // ------------------------------------------------------------------

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input umcfp_pkg::in_item_t it);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        decode_rx_item(it);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        umcfp_pkg::in_item_t it;
        it.func = 1'b0;
        it.rx_byte = b;
        it.chunk_end = last;
        it.mode_write = 4'($urandom);
        send_item(it);
    endtask

    task automatic send_mode(input logic [3:0] m);
        umcfp_pkg::in_item_t it;
        it.func = 1'b1;
        it.rx_byte = 8'($urandom);
        it.chunk_end = 1'($urandom);
        it.mode_write = m;
        send_item(it);
    endtask

    task automatic send_chunk(input byte_q_t q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic byte_q_t bytes_of(input logic [63:0] v, input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
        return q;
    endfunction

    function automatic byte_q_t rand_bytes(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        return q;
    endfunction

    // 55 AA LEN ID CMD payload SUM, sum over LEN..end of payload
    function automatic byte_q_t make_frame(input logic [7:0] id, input logic [7:0] cmd,
                                           input byte_q_t payload);
        byte_q_t    f;
        logic [7:0] sum;
        f.push_back(umcfp_pkg::SYNC_FIRST);
        f.push_back(umcfp_pkg::SYNC_SECOND);
        f.push_back(8'(payload.size() + 1));
        f.push_back(id);
        f.push_back(cmd);
        foreach (payload[i]) f.push_back(payload[i]);
        sum = '0;
        for (int i = 2; i < f.size(); i++) sum = sum + f[i];
        f.push_back(sum);
        return f;
    endfunction

    task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input byte_q_t payload);
        send_chunk(make_frame(id, cmd, payload));
    endtask

    // Hold the sender until every status is back and the block has gone quiet
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [umcfp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [umcfp_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            umcfp_pkg::REG_DEVICE_ADDRESS: dev_addr_q = value[7:0];
            umcfp_pkg::REG_TICK_RATE:      tick_rate_q = value[19:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_registers(input logic [7:0] addr, input logic [19:0] tick);
        wait_results_done();
        write_register(umcfp_pkg::REG_DEVICE_ADDRESS, umcfp_pkg::CFG_DATA_W'(addr));
        write_register(umcfp_pkg::REG_TICK_RATE, tick);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each rejection reason in turn, with reset register values
    task automatic test_frame_checks();
        byte_q_t q;
        send_byte(umcfp_pkg::SYNC_FIRST, 1'b1);
        send_chunk(bytes_of(64'h25_01_01_AA_55, 5));          // five bytes: too small
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_PLUS,
                       bytes_of(0, 0));
        q[0] = 8'h54;
        send_chunk(q);                                          // bad first sync
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_PLUS,
                       bytes_of(0, 0));
        q[1] = 8'h2A;
        send_chunk(q);                                          // bad second sync
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_REPEAT,
                       rand_bytes(6));
        repeat (4) void'(q.pop_back());
        send_chunk(q);                                          // short for its length
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_POSITION,
                       bytes_of(64'hFF00FF00, 4));
        q[q.size()-1] = q[q.size()-1] ^ 8'h01;
        send_chunk(q);                                          // checksum error
        send_frame(8'h02, umcfp_pkg::CMD_STEP_PLUS, bytes_of(0, 0));   // foreign id
        send_mode(umcfp_pkg::MODE_FAULT_A);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STOP, bytes_of(0, 0));
        send_mode(umcfp_pkg::MODE_FAULT_C);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_REPEAT, bytes_of(0, 0));
        send_mode(umcfp_pkg::MODE_IDLE);
    endtask

    // Every command, full payloads and missing payload offsets
    task automatic test_command_decode();
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_REPEAT,
                   bytes_of(64'h0A_12_34_20_FF_77, 6));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_REPEAT, bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STOP, bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_POSITION,
                   bytes_of(64'h80_00_FF_11, 4));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_PLUS,
                   bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_MINUS,
                   bytes_of(64'hFF, 1));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                   bytes_of(64'h7FFF, 2));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                   bytes_of(64'h8000, 2));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                   bytes_of(64'hFFFF, 2));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                   bytes_of(64'h05, 1));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_CLOSED_POS,
                   bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_CLOSED_FRC,
                   bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, CMD_ENABLE_ONLY, bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, 8'hFF, bytes_of(0, 0));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, 8'h00, bytes_of(0, 0));
    endtask

    // External mode writes: error survives stop, out-of-range modes, mid-chunk write
    task automatic test_mode_writes();
        byte_q_t q;
        send_mode(umcfp_pkg::MODE_ERROR);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STOP, bytes_of(0, 0));
        send_mode(4'd11);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_PLUS,
                   bytes_of(0, 0));
        send_mode(4'd15);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, CMD_ENABLE_ONLY, bytes_of(0, 0));
        send_mode(umcfp_pkg::MODE_FAULT_B);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STEP_MINUS,
                   bytes_of(0, 0));
        // print flag: kept on a tiny chunk, raised on a bad header in open position
        send_mode(umcfp_pkg::MODE_OPEN_POS);
        send_byte(8'h00, 1'b1);
        send_chunk(bytes_of(64'h00_00_00_00_00_00, 6));
        // fault written part way through a chunk blocks that chunk
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                       bytes_of(64'h0100, 2));
        foreach (q[i]) begin
            if (i == 3) send_mode(umcfp_pkg::MODE_FAULT_A);
            send_byte(q[i], i == q.size() - 1);
        end
        send_mode(umcfp_pkg::MODE_IDLE);
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_STOP, bytes_of(0, 0));
    endtask

    // Chunks longer than the store: the tail is ignored, the size saturates
    task automatic test_oversized_chunk();
        byte_q_t q, tail;
        q = make_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_REPEAT,
                       rand_bytes(250));
        tail = rand_bytes(44);
        foreach (tail[i]) q.push_back(tail[i]);
        send_chunk(q);
        q = rand_bytes(260);
        q[0] = umcfp_pkg::SYNC_FIRST;
        q[1] = umcfp_pkg::SYNC_SECOND;
        q[2] = 8'hFF;
        send_chunk(q);
    endtask

    // Register extremes: address 0 and 255, tick rates 1, 2^20-1, 0 and a typical one
    task automatic test_register_extremes();
        set_registers(8'h00, 20'd1);
        send_frame(8'h00, umcfp_pkg::CMD_STEP_PLUS, bytes_of(0, 0));
        send_frame(8'h00, umcfp_pkg::CMD_VELOCITY, bytes_of(64'h7FFF, 2));
        send_frame(umcfp_pkg::DEVICE_ADDRESS_RESET, umcfp_pkg::CMD_VELOCITY,
                   bytes_of(64'h7FFF, 2));
        set_registers(8'hFF, 20'hFFFFF);
        send_frame(8'hFF, umcfp_pkg::CMD_STEP_MINUS, bytes_of(0, 0));
        send_frame(8'hFF, umcfp_pkg::CMD_VELOCITY, bytes_of(64'h0001, 2));
        set_registers(8'hFF, 20'd0);
        send_frame(8'hFF, umcfp_pkg::CMD_STEP_PLUS, bytes_of(0, 0));
        send_frame(8'hFF, umcfp_pkg::CMD_VELOCITY, bytes_of(64'h7FFF, 2));
        send_frame(8'hFF, umcfp_pkg::CMD_VELOCITY, bytes_of(64'h8000, 2));
        set_registers(8'h01, 20'd1000000);
        send_frame(8'h01, umcfp_pkg::CMD_VELOCITY, bytes_of(64'h1234, 2));
        send_frame(8'h01, umcfp_pkg::CMD_STEP_PLUS, bytes_of(0, 0));
    endtask

    // One random chunk: mostly good frames, some damaged, some line noise
    task automatic send_random_chunk();
        byte_q_t    q;
        int         n, k;
        logic [7:0] cmd;
        if ($urandom_range(9, 0) == 0)
            send_mode(($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 8))
                                                  : 4'($urandom_range(7, 0)));
        if ($urandom_range(99, 0) < 20) begin
            q = rand_bytes($urandom_range(12, 1));
            if (q.size() > 2 && $urandom_range(1, 0) == 1) begin
                q[0] = umcfp_pkg::SYNC_FIRST;
                q[1] = umcfp_pkg::SYNC_SECOND;
            end
        end else begin
            n = ($urandom_range(29, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 0);
            k = $urandom_range(10, 0);
            cmd = (k < 8) ? KNOWN_CMDS[k] : (k == 8) ? CMD_ENABLE_ONLY : 8'($urandom);
            q = make_frame(($urandom_range(9, 0) == 0) ? 8'($urandom) : dev_addr_q,
                           cmd, rand_bytes(n));
            // occasional damage
            case ($urandom_range(19, 0))
                0: begin
                    k = $urandom_range(1, 0);
                    q[k] = q[k] ^ 8'(1 << $urandom_range(7, 0));
                end
                1: q[q.size()-1] = q[q.size()-1] ^ 8'($urandom_range(255, 1));
                2: repeat ($urandom_range(q.size() - 1, 1)) void'(q.pop_back());
                3: q[2] = 8'($urandom);
                4: repeat ($urandom_range(4, 1)) q.push_back(8'($urandom));
                default: ;
            endcase
        end
        send_chunk(q);
    endtask

    // Random traffic in four pacing phases, each with its own register setting
    task automatic test_random_traffic();
        int stop_at;
        int per_phase;
        per_phase = (TOTAL_ITEMS - n_items) / 4;
        if (per_phase < 40) per_phase = 40;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_registers(8'($urandom), umcfp_pkg::TICK_RATE_RESET);
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    set_registers(8'hFF, 20'hFFFFF);
                    src_idle_pct = 79;
                    sink_stall_pct = 0;
                end
                2: begin
                    set_registers(8'h00, 20'($urandom_range(1000000, 1)));
                    src_idle_pct = 0;
                    sink_stall_pct = 79;
                end
                default: begin
                    set_registers(8'($urandom), ($urandom_range(3, 0) == 0) ? 20'd0
                                                                            : 20'($urandom));
                    src_idle_pct = 14;
                    sink_stall_pct = 14;
                end
            endcase
            stop_at = n_items + per_phase;
            while (n_items < stop_at) begin
                send_random_chunk();
                // sometimes let the result side run dry
                if ($urandom_range(24, 0) == 0) wait_results_done();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_chunk();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_frame_checks();
        test_command_decode();
        test_mode_writes();
        test_oversized_chunk();
        test_register_extremes();
        test_random_traffic();

        wait_results_done();
        $display("Run: %0d transfers, %0d chunks, %0d results checked, %0d mode writes;",
                 n_items, n_chunks, n_checked, n_mode_writes);
        $display("all frame checks, commands, oversized chunks, extremes and four pacings");
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
